// ===== rtl/utpm_pkg.sv =====
// Package for the TDOA pair matcher: frame and result word types, frame codes,
// the sequencer state type and the fixed-point constants.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package utpm_pkg;

  localparam int unsigned TableDepthDef = 4;
  localparam int unsigned FracBits      = 26;
  localparam int unsigned StampW        = 40;
  localparam int unsigned IdW           = 8;
  localparam int unsigned ReplyW        = 32;
  localparam int unsigned OffsetW       = 16;
  localparam int unsigned ProdW         = ReplyW + OffsetW;
  localparam int unsigned CalcW         = 44;
  localparam int unsigned TdoaW         = 42;
  localparam int unsigned EntryW        = IdW + StampW;
  localparam int unsigned TdoaCntW      = 3;

  localparam logic [9:0]          MaxLen    = 10'd128;
  localparam logic [TdoaCntW-1:0] BatchSize = 3'd4;

  localparam logic [1:0] KindSync     = 2'd0;
  localparam logic [1:0] KindBlink    = 2'd1;
  localparam logic [1:0] KindResponse = 2'd2;
  localparam logic [1:0] KindIgnored  = 2'd3;

  typedef struct packed {
    logic [1:0]                frame_kind;
    logic [9:0]                frame_length;
    logic [IdW-1:0]            sender_id;
    logic [IdW-1:0]            master_ref;
    logic [StampW-1:0]         rx_stamp;
    logic signed [ReplyW-1:0]  reply_delay;
    logic signed [OffsetW-1:0] clock_offset;
  } frame_word_t;

  typedef struct packed {
    logic signed [TdoaW-1:0] tdoa_value;
    logic [IdW-1:0]          master_id;
    logic [IdW-1:0]          slave_id;
    logic                    batch_full;
    logic                    last;
  } result_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_FINISH
  } seq_state_e;

endpackage

// ===== rtl/utpm_calc.sv =====
// Corrected TDOA datapath: registered reply-times-offset product, a per-entry
// bias term, and the final add with rounding toward zero.
// Depends on utpm_pkg.
`timescale 1ns / 1ps

module utpm_calc (
  input  logic                                    clk_i,
  input  logic                                    load_i,
  input  logic                                    prep_i,
  input  logic signed [utpm_pkg::ReplyW-1:0]      reply_i,
  input  logic signed [utpm_pkg::OffsetW-1:0]     offset_i,
  input  logic [utpm_pkg::StampW-1:0]             rx_stamp_i,
  input  logic [utpm_pkg::StampW-1:0]             master_time_i,
  output logic signed [utpm_pkg::TdoaW-1:0]       tdoa_o
);
  import utpm_pkg::*;

  logic signed [ProdW-1:0]  prod_q;
  logic signed [ReplyW-1:0] reply_q;
  logic signed [CalcW-1:0]  bias_q;
  logic                     frac_nz_q;
  logic signed [CalcW-1:0]  diff;
  logic signed [CalcW-1:0]  base;
  logic signed [CalcW-1:0]  base_adj;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q  <= ProdW'(reply_i) * ProdW'(offset_i);
      reply_q <= reply_i;
    end
    // The floored quotient and the remainder flag are split off here so the
    // scan cycle only sees a subtract, an add and an increment.
    if (prep_i) begin
      bias_q    <= CalcW'(prod_q >>> FracBits) - CalcW'(reply_q);
      frac_nz_q <= |prod_q[FracBits-1:0];
    end
  end

  always_comb begin
    diff     = $signed({{(CalcW-StampW){1'b0}}, rx_stamp_i})
             - $signed({{(CalcW-StampW){1'b0}}, master_time_i});
    base     = diff + bias_q;
    // A negative sum with a nonzero fraction moves up by one: truncation
    // toward zero.
    base_adj = base + $signed({{(CalcW-1){1'b0}}, base[CalcW-1] & frac_nz_q});
  end

  assign tdoa_o = base_adj[TdoaW-1:0];

endmodule

// ===== rtl/uwb_tdoa_pair_matcher.sv =====
// TDOA pair matcher. A frame is taken when start is high and busy is low.
// Blinks, dropped frames and responses to an empty table give no result; busy stays low.
// A response scans the master table entry by entry (memory read, then compare and compute),
// then flushes, busy high throughout; it stops at the last stored entry or a full batch.
// Each result word is strobed for one cycle, cannot be stalled, the last as busy falls.
// Asynchronous active-low reset empties the table and clears both counts.
`timescale 1ns / 1ps

module uwb_tdoa_pair_matcher #(
  parameter int unsigned TableDepth = utpm_pkg::TableDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  utpm_pkg::frame_word_t  in_word_i,
  output logic                   strobe,
  output utpm_pkg::result_word_t result_o
);
  import utpm_pkg::*;

  localparam int unsigned IdxW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW = $clog2(TableDepth + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TableDepth);

  seq_state_e            state_q, state_d;
  logic [CntW-1:0]       mcount_q, mcount_d;
  logic [TdoaCntW-1:0]   tcount_q, tcount_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  frame_word_t           frame_q;
  result_word_t          pend_q, pend_d;
  logic                  pend_vld_q, pend_vld_d;
  result_word_t          out_q, out_d;
  logic                  strobe_q, strobe_d;

  logic [EntryW-1:0]     mem_q [TableDepth];
  logic [EntryW-1:0]     rd_q;
  logic                  mem_we;
  logic                  accept;
  logic                  keep;
  logic                  do_read;
  logic                  match;
  logic                  full;
  logic                  scan_end;
  logic signed [TdoaW-1:0] tdoa;

  assign accept   = start && (state_q == ST_IDLE);
  assign keep     = in_word_i.frame_length < MaxLen;
  assign match    = rd_q[EntryW-1 -: IdW] == frame_q.master_ref;
  assign full     = (tcount_q + TdoaCntW'(1)) == BatchSize;
  assign scan_end = (CntW'(idx_q) + CntW'(1)) == mcount_q;

  // Table memory: written by blinks while idle, read once per scan step.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mcount_q[IdxW-1:0]] <= {in_word_i.sender_id, in_word_i.rx_stamp};
    end
    if (do_read) begin
      rd_q <= mem_q[idx_q];
    end
    if (accept) begin
      frame_q <= in_word_i;
    end
  end

  utpm_calc u_calc (
    .clk_i         (clk_i),
    .load_i        (accept),
    .prep_i        (do_read),
    .reply_i       (in_word_i.reply_delay),
    .offset_i      (in_word_i.clock_offset),
    .rx_stamp_i    (frame_q.rx_stamp),
    .master_time_i (rd_q[StampW-1:0]),
    .tdoa_o        (tdoa)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && keep && in_word_i.frame_kind == KindResponse && mcount_q != '0) begin
          state_d = ST_READ;
        end
      end
      ST_READ:   state_d = ST_CALC;
      ST_CALC: begin
        if ((match && full) || scan_end) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    mcount_d   = mcount_q;
    tcount_d   = tcount_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    strobe_d   = 1'b0;
    mem_we     = 1'b0;
    do_read    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && keep) begin
          if (in_word_i.frame_kind == KindBlink && mcount_q < DepthCnt) begin
            mem_we   = 1'b1;
            mcount_d = mcount_q + CntW'(1);
          end
          idx_d      = '0;
          pend_vld_d = 1'b0;
        end
      end
      ST_READ: begin
        do_read = 1'b1;
      end
      ST_CALC: begin
        idx_d = idx_q + IdxW'(1);
        if (match) begin
          // The previous result goes out now; it is known not to be the last.
          if (pend_vld_q) begin
            out_d    = pend_q;
            strobe_d = 1'b1;
          end
          pend_d.tdoa_value = tdoa;
          pend_d.master_id  = frame_q.master_ref;
          pend_d.slave_id   = frame_q.sender_id;
          pend_d.batch_full = full;
          pend_d.last       = 1'b0;
          pend_vld_d        = 1'b1;
          if (full) begin
            tcount_d = '0;
            mcount_d = '0;
          end else begin
            tcount_d = tcount_q + TdoaCntW'(1);
          end
        end
      end
      ST_FINISH: begin
        if (pend_vld_q) begin
          out_d      = pend_q;
          out_d.last = 1'b1;
          strobe_d   = 1'b1;
        end
        pend_vld_d = 1'b0;
      end
      default: begin
        pend_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      mcount_q   <= '0;
      tcount_q   <= '0;
      idx_q      <= '0;
      pend_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      mcount_q   <= mcount_d;
      tcount_q   <= tcount_d;
      idx_q      <= idx_d;
      pend_vld_q <= pend_vld_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign busy     = state_q != ST_IDLE;
  assign strobe   = strobe_q;
  assign result_o = out_q;

`ifndef NO_ASSERTIONS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcount_q <= DepthCnt && tcount_q < BatchSize)
    else $error("table or batch count out of range");

  a_full_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && result_o.batch_full |-> mcount_q == '0 && tcount_q == '0)
    else $error("batch end did not clear the table");

  a_full_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe && result_o.batch_full |-> result_o.last)
    else $error("batch end word not marked last");

  a_finish_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |=> !busy && !pend_vld_q)
    else $error("pending word left after scan");
`endif

endmodule

// ===== sim/tb_uwb_tdoa_pair_matcher.sv =====
// Self-checking testbench for uwb_tdoa_pair_matcher: directed and random frame words,
// results predicted in the bench and compared word by word as they are strobed out.
// Depends on utpm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module tb_uwb_tdoa_pair_matcher;
  import utpm_pkg::*;

  localparam int unsigned IdleLimit = 2000;

  logic         clk_i;
  logic         rst_ni;
  logic         start;
  logic         busy;
  frame_word_t  in_word_i;
  logic         strobe;
  result_word_t result_o;

  // Shadow copy of the master table and the batch counter.
  logic [IdW-1:0]    tbl_ids   [TableDepthDef];
  logic [StampW-1:0] tbl_times [TableDepthDef];
  int unsigned       tbl_count;
  int unsigned       pair_count;

  result_word_t pending_tdoa_q[$];
  result_word_t want_w;

  int unsigned frames_sent;
  int unsigned useful_frames;
  int unsigned results_seen;
  int unsigned errors;
  int unsigned idle_cycles;
  bit          no_idle;

  uwb_tdoa_pair_matcher i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .in_word_i(in_word_i),
    .strobe   (strobe),
    .result_o (result_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic void clear_table();
    for (int i = 0; i < TableDepthDef; i++) begin
      tbl_ids[i]   = '0;
      tbl_times[i] = '0;
    end
    tbl_count  = 0;
    pair_count = 0;
  endfunction

  // (rx - master) - reply * (1 - off / 2^26), exact and truncated toward zero.
  function automatic longint corrected_tdoa(logic [StampW-1:0] rx, logic [StampW-1:0] mrx,
                                            logic signed [ReplyW-1:0] reply,
                                            logic signed [OffsetW-1:0] off);
    longint       whole;
    longint       prod;
    longint       base;
    logic [25:0]  frac;
    whole = longint'({24'd0, rx}) - longint'({24'd0, mrx}) - longint'(reply);
    prod  = longint'(reply) * longint'(off);
    frac  = prod[FracBits-1:0];
    base  = whole + (prod >>> FracBits);
    if (base < 0 && frac != 0) begin
      base = base + 1;
    end
    return base;
  endfunction

  function automatic void predict_pairs(frame_word_t w);
    result_word_t found [4];
    int unsigned  n;
    longint       t;
    n = 0;
    frames_sent++;
    if (w.frame_length >= MaxLen) begin
      return;
    end
    if (w.frame_kind == KindBlink) begin
      useful_frames++;
      if (tbl_count < TableDepthDef) begin
        tbl_ids[tbl_count]   = w.sender_id;
        tbl_times[tbl_count] = w.rx_stamp;
        tbl_count++;
      end
      return;
    end
    if (w.frame_kind != KindResponse) begin
      return;
    end
    useful_frames++;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_ids[i] == w.master_ref) begin
        t = corrected_tdoa(w.rx_stamp, tbl_times[i], w.reply_delay, w.clock_offset);
        found[n].tdoa_value = t[TdoaW-1:0];
        found[n].master_id  = w.master_ref;
        found[n].slave_id   = w.sender_id;
        found[n].batch_full = 1'b0;
        found[n].last       = 1'b0;
        n++;
        pair_count++;
        if (pair_count >= BatchSize) begin
          // The batch closes here: the table empties and the scan stops.
          found[n-1].batch_full = 1'b1;
          clear_table();
          break;
        end
      end
    end
    if (n > 0) begin
      found[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      pending_tdoa_q.push_back(found[i]);
    end
  endfunction

  function automatic frame_word_t make_frame(logic [1:0] kind, logic [9:0] len,
                                             logic [7:0] sender, logic [7:0] mref,
                                             logic [39:0] rx, logic [31:0] reply,
                                             logic [15:0] off);
    frame_word_t w;
    w.frame_kind   = kind;
    w.frame_length = len;
    w.sender_id    = sender;
    w.master_ref   = mref;
    w.rx_stamp     = rx;
    w.reply_delay  = reply;
    w.clock_offset = off;
    return w;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 60) begin
      return 0;
    end
    if (p < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offers one word, waits for it to be taken, then idles for a random gap.
  // With a zero gap start stays high, so the next call must follow in the same step.
  task automatic send_frame(frame_word_t w);
    int unsigned gap;
    start     <= 1'b1;
    in_word_i <= w;
    do begin
      @(posedge clk_i);
    end while (busy !== 1'b0);
    predict_pairs(w);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Always waits at least one edge, so start is never driven twice in one step.
  task automatic drain_results();
    start <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_tdoa_q.size() != 0);
  endtask

  task automatic report_field(string name, logic [63:0] expv, logic [63:0] gotv);
    if (expv !== gotv) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, expv, gotv);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe) begin
      if (pending_tdoa_q.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %0h", $time, result_o);
        errors++;
      end else begin
        want_w = pending_tdoa_q.pop_front();
        results_seen++;
        report_field("tdoa_value", 64'(want_w.tdoa_value), 64'(result_o.tdoa_value));
        report_field("master_id", 64'(want_w.master_id), 64'(result_o.master_id));
        report_field("slave_id", 64'(want_w.slave_id), 64'(result_o.slave_id));
        report_field("batch_full", 64'(want_w.batch_full), 64'(result_o.batch_full));
        report_field("last", 64'(want_w.last), 64'(result_o.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: timeout, no word moved for %0d cycles", $time, IdleLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic test_dropped_frames();
    send_frame(make_frame(KindBlink, 10'd128, 8'h11, 8'h00, 40'h12_3456_789A, 32'd5, 16'd0));
    send_frame(make_frame(KindBlink, 10'd1023, 8'h22, 8'h00, 40'h00_0000_0100, 32'd5, 16'd0));
    send_frame(make_frame(KindSync, 10'd10, 8'h33, 8'h00, 40'h00_0000_0200, 32'd0, 16'd0));
    send_frame(make_frame(KindIgnored, 10'd10, 8'h44, 8'h00, 40'h00_0000_0300, 32'd0,
                          16'd0));
    // Empty table: a response matches nothing.
    send_frame(make_frame(KindResponse, 10'd127, 8'h55, 8'h00, 40'h00_0000_0400, 32'd7,
                          16'd3));
  endtask

  task automatic test_full_table_and_duplicates();
    send_frame(make_frame(KindBlink, 10'd127, 8'h00, 8'h00, 40'h00_0000_0000, 32'd0, 16'd0));
    send_frame(make_frame(KindBlink, 10'd0, 8'hFF, 8'h00, 40'hFF_FFFF_FFFF, 32'd0, 16'd0));
    send_frame(make_frame(KindBlink, 10'd20, 8'hFF, 8'h00, 40'h00_0000_1000, 32'd0, 16'd0));
    send_frame(make_frame(KindBlink, 10'd20, 8'h3C, 8'h00, 40'h55_AA55_AA55, 32'd0, 16'd0));
    // The table is full, so this master is never stored.
    send_frame(make_frame(KindBlink, 10'd20, 8'h77, 8'h00, 40'h00_0000_2000, 32'd0, 16'd0));
    send_frame(make_frame(KindResponse, 10'd20, 8'h99, 8'h77, 40'h00_0000_3000, 32'd9,
                          16'd1));
    send_frame(make_frame(KindResponse, 10'd20, 8'hA5, 8'hFF, 40'h00_0000_2000, 32'd1000,
                          16'd0));
    send_frame(make_frame(KindResponse, 10'd20, 8'h5A, 8'h00, 40'hFF_FFFF_FFFF,
                          32'h8000_0000, 16'h8000));
    // Two entries match but the batch closes on the first.
    send_frame(make_frame(KindResponse, 10'd20, 8'h5B, 8'hFF, 40'h00_0100_0000,
                          32'd123456, 16'h1234));
    send_frame(make_frame(KindResponse, 10'd20, 8'h5C, 8'hFF, 40'h00_0100_0000, 32'd1,
                          16'd1));
    drain_results();
  endtask

  task automatic test_batch_end();
    for (int i = 0; i < 4; i++) begin
      send_frame(make_frame(KindBlink, 10'd30, 8'h42, 8'h00, 40'(64'h10_0000_0000 + i * 77),
                            32'd0, 16'd0));
    end
    send_frame(make_frame(KindResponse, 10'd30, 8'hC3, 8'h42, 40'h10_0001_0000,
                          32'h7FFF_FFFF, 16'h7FFF));
  endtask

  task automatic test_extremes();
    send_frame(make_frame(KindBlink, 10'd40, 8'h81, 8'h00, 40'hFF_FFFF_FFFF, 32'd0, 16'd0));
    // Product is an exact multiple of one unit, so no rounding.
    send_frame(make_frame(KindResponse, 10'd40, 8'h01, 8'h81, 40'h00_0000_0000,
                          32'h0400_0000, 16'd1));
    send_frame(make_frame(KindResponse, 10'd40, 8'hFF, 8'h81, 40'h00_0000_0000,
                          32'h8000_0000, 16'h7FFF));
    send_frame(make_frame(KindResponse, 10'd40, 8'h02, 8'h81, 40'hFF_FFFF_FFFF,
                          32'hFFFF_FFFF, 16'd1));
    send_frame(make_frame(KindResponse, 10'd200, 8'h03, 8'h81, 40'hFF_FFFF_FFFF, 32'd1,
                          16'd1));
    drain_results();
  endtask

  task automatic test_random();
    logic [7:0]   ids [4];
    logic [39:0]  base_rx;
    logic [31:0]  reply;
    logic [7:0]   mref;
    logic [39:0]  rx;
    logic [9:0]   len;
    int unsigned  nb;
    int unsigned  nr;
    int unsigned  stop_at;
    stop_at = frames_sent + 285;
    while (frames_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 24) == 0) begin
        drain_results();
      end
      if ($urandom_range(0, 9) < 7) begin
        // A well-formed exchange: blinks from masters, then responses that mostly refer to them.
        base_rx = 40'({$urandom(), $urandom()});
        nb = $urandom_range(1, 4);
        for (int i = 0; i < nb; i++) begin
          ids[i] = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7)) : 8'($urandom());
          send_frame(make_frame(KindBlink, 10'($urandom_range(0, 127)), ids[i], 8'($urandom()),
                                base_rx + 40'($urandom_range(0, 1000)), $urandom(),
                                16'($urandom())));
        end
        nr = $urandom_range(1, 3);
        for (int i = 0; i < nr; i++) begin
          mref  = ($urandom_range(0, 9) < 8) ? ids[$urandom_range(0, nb - 1)] : 8'($urandom());
          rx    = ($urandom_range(0, 9) < 8) ? base_rx + 40'($urandom_range(0, 1 << 20))
                                              : 40'({$urandom(), $urandom()});
          reply = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 1 << 24)) : $urandom();
          send_frame(make_frame(KindResponse, 10'($urandom_range(0, 127)), 8'($urandom()),
                                mref, rx, reply, 16'($urandom())));
        end
      end else begin
        len = ($urandom_range(0, 1) == 0) ? 10'($urandom_range(0, 127)) : 10'($urandom());
        send_frame(make_frame(2'($urandom()), len, 8'($urandom()), 8'($urandom()),
                              40'({$urandom(), $urandom()}), $urandom(), 16'($urandom())));
      end
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    in_word_i     = '0;
    frames_sent   = 0;
    useful_frames = 0;
    results_seen  = 0;
    errors        = 0;
    idle_cycles   = 0;
    no_idle       = 1'b0;
    clear_table();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_dropped_frames();
    test_full_table_and_duplicates();
    test_batch_end();
    test_extremes();
    test_random();

    repeat (20) @(posedge clk_i);
    if (pending_tdoa_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_tdoa_q.size());
      errors++;
    end
    $display("Sent %0d frames (%0d blinks or responses), checked %0d TDOA results;",
             frames_sent, useful_frames, results_seen);
    $display("covered dropped and long frames, a full table, duplicate masters, batch ends.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
